// ===== sv/pat_pkg.sv =====
// Shared types and codes for the presence aging table.
`default_nettype none

package pat_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KEY_W         = 32;

    // Command opcodes
    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_MARK   = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_POLL   = 3'd4;

    typedef enum logic [3:0] {
        STATUS_ADDED    = 4'd0,
        STATUS_DUP      = 4'd1,
        STATUS_FULL     = 4'd2,
        STATUS_MARKED   = 4'd3,
        STATUS_REMOVED  = 4'd4,
        STATUS_NOTFOUND = 4'd5,
        STATUS_EXPIRED  = 4'd6,
        STATUS_NONE     = 4'd7,
        STATUS_POLL     = 4'd8
    } pat_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP
    } pat_state_t;

    // What every cell does this cycle
    typedef enum logic [2:0] {
        MODE_HOLD,
        MODE_APPEND,
        MODE_MARK,
        MODE_REMOVE,
        MODE_KEEP,
        MODE_DROP
    } pat_mode_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             seen;
    } pat_entry_t;

    typedef struct packed {
        pat_mode_t        mode;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] head_key;
    } pat_ctl_t;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [KEY_W-1:0] address_key;
    } pat_cmd_t;

    typedef struct packed {
        logic [3:0]       status;
        logic [KEY_W-1:0] expired_key;
        logic             update_flag;
        logic [4:0]       entry_count;
        logic             last;
    } pat_rsp_t;

endpackage

`default_nettype wire

// ===== sv/presence_aging_table.sv =====
// Add, mark, remove and poll pass through the exec state and give a registered result;
// a new command is taken only back in idle. During a tick over N entries the cell row rotates
// one entry past the head per cycle; each expired entry is reported the cycle after.
// Results are single-cycle strobes on rsp_valid; the receiver cannot stall.
// Reset empties the table and clears the seen bits and the pending flag; stored keys
// are not reset.
`default_nettype none

module presence_aging_table #(
    parameter int DEPTH = pat_pkg::DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire pat_pkg::pat_cmd_t cmd,
    output logic                   busy,
    output logic                   rsp_valid,
    output pat_pkg::pat_rsp_t      rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    pat_pkg::pat_state_t state_reg, state_next;
    logic [2:0]                op_reg, op_next;
    logic [pat_pkg::KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          rem_reg, rem_next;
    logic                      pending_reg, pending_next;
    logic                      found_reg, found_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    pat_pkg::pat_rsp_t         rsp_reg, rsp_next;

    pat_pkg::pat_ctl_t   ctl;
    pat_pkg::pat_entry_t entries [DEPTH];
    pat_pkg::pat_entry_t nbrs    [DEPTH];
    logic [DEPTH-1:0]    hits;
    logic [DEPTH-1:0]    stales;
    logic [DEPTH:0]      shifts;
    logic                any_hit;
    logic                any_stale;
    logic                accept;

    assign busy      = state_reg != pat_pkg::S_IDLE;
    assign accept    = start && !busy;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign any_hit   = |hits;
    assign any_stale = |stales;
    assign shifts[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == DEPTH - 1)
            begin : g_end
                assign nbrs[gi] = '0;
            end
            else
            begin : g_mid
                assign nbrs[gi] = entries[gi + 1];
            end

            pat_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .count     (count_reg),
                .rem       (rem_reg),
                .nbr       (nbrs[gi]),
                .shift_in  (shifts[gi]),
                .entry     (entries[gi]),
                .hit       (hits[gi]),
                .shift_out (shifts[gi + 1]),
                .stale     (stales[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        pending_next   = pending_reg;
        found_next     = found_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = rsp_reg;

        ctl.mode     = pat_pkg::MODE_HOLD;
        ctl.key      = key_reg;
        ctl.head_key = entries[0].key;

        unique case (state_reg)
            pat_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = cmd.opcode;
                    key_next   = cmd.address_key;
                    state_next = pat_pkg::S_EXEC;
                end
            end

            pat_pkg::S_EXEC:
            begin
                state_next           = pat_pkg::S_IDLE;
                rsp_next.expired_key = '0;
                rsp_next.update_flag = pending_reg;
                rsp_next.last        = 1'b1;
                rsp_valid_next       = 1'b1;
                case (op_reg)
                    pat_pkg::OP_ADD:
                    begin
                        if (any_hit)
                            rsp_next.status = pat_pkg::STATUS_DUP;
                        else if (count_reg == CNT_W'(DEPTH))
                            rsp_next.status = pat_pkg::STATUS_FULL;
                        else
                        begin
                            ctl.mode        = pat_pkg::MODE_APPEND;
                            count_next      = count_reg + CNT_W'(1);
                            rsp_next.status = pat_pkg::STATUS_ADDED;
                        end
                    end
                    pat_pkg::OP_MARK:
                    begin
                        if (any_hit)
                        begin
                            ctl.mode        = pat_pkg::MODE_MARK;
                            rsp_next.status = pat_pkg::STATUS_MARKED;
                        end
                        else
                            rsp_next.status = pat_pkg::STATUS_NOTFOUND;
                    end
                    pat_pkg::OP_REMOVE:
                    begin
                        if (any_hit)
                        begin
                            ctl.mode        = pat_pkg::MODE_REMOVE;
                            count_next      = count_reg - CNT_W'(1);
                            rsp_next.status = pat_pkg::STATUS_REMOVED;
                        end
                        else
                            rsp_next.status = pat_pkg::STATUS_NOTFOUND;
                    end
                    pat_pkg::OP_TICK:
                    begin
                        rsp_next.status = pat_pkg::STATUS_NONE;
                        if (count_reg != '0)
                        begin
                            rsp_valid_next = 1'b0;
                            rem_next       = count_reg;
                            found_next     = 1'b0;
                            state_next     = pat_pkg::S_SWEEP;
                        end
                    end
                    pat_pkg::OP_POLL:
                    begin
                        rsp_next.status = pat_pkg::STATUS_POLL;
                        pending_next    = 1'b0;
                    end
                    default:
                    begin
                        rsp_valid_next = 1'b0;
                    end
                endcase
                rsp_next.entry_count = 5'(count_next);
            end

            pat_pkg::S_SWEEP:
            begin
                // one entry past the head per cycle
                rem_next = rem_reg - CNT_W'(1);
                if (rem_reg == CNT_W'(1))
                    state_next = pat_pkg::S_IDLE;
                rsp_next.expired_key = '0;
                if (!entries[0].seen)
                begin
                    ctl.mode             = pat_pkg::MODE_DROP;
                    count_next           = count_reg - CNT_W'(1);
                    pending_next         = 1'b1;
                    found_next           = 1'b1;
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = pat_pkg::STATUS_EXPIRED;
                    rsp_next.expired_key = entries[0].key;
                    rsp_next.update_flag = 1'b1;
                    rsp_next.last        = !any_stale;
                end
                else
                begin
                    ctl.mode             = pat_pkg::MODE_KEEP;
                    rsp_next.status      = pat_pkg::STATUS_NONE;
                    rsp_next.update_flag = pending_reg;
                    rsp_next.last        = 1'b1;
                    rsp_valid_next       = (rem_reg == CNT_W'(1)) && !found_reg;
                end
                rsp_next.entry_count = 5'(count_next);
            end

            default:
            begin
                state_next = pat_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pat_pkg::S_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            pending_reg   <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            pending_reg   <= pending_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
        rsp_reg <= rsp_next;
    end

`ifndef SYNTHESIS
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> $past(state_reg) != pat_pkg::S_IDLE)
        else $error("result strobe without work in progress");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    a_sweep_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pat_pkg::S_SWEEP |-> (rem_reg != '0) && (rem_reg <= count_reg))
        else $error("sweep counter out of range");

    a_expired_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.status == pat_pkg::STATUS_EXPIRED) |-> pending_reg)
        else $error("expiry without pending update");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pat_pkg::S_SWEEP |=> state_reg != pat_pkg::S_EXEC)
        else $error("item taken during sweep");
`endif

endmodule

`default_nettype wire

// ===== sv/pat_cell.sv =====
// One table slot: key and seen bit, shifting toward the head on delete or rotate.
`default_nettype none

module pat_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pat_pkg::pat_ctl_t  ctl,
    input  wire logic [CNT_W-1:0]   count,
    input  wire logic [CNT_W-1:0]   rem,
    input  wire pat_pkg::pat_entry_t nbr,
    input  wire logic               shift_in,
    output pat_pkg::pat_entry_t     entry,
    output logic                    hit,
    output logic                    shift_out,
    output logic                    stale
);

    logic [pat_pkg::KEY_W-1:0] key_reg, key_next;
    logic                      seen_reg, seen_next;
    logic                      valid;
    logic                      is_tail;
    logic                      is_free;

    assign valid     = CNT_W'(IDX) < count;
    assign is_tail   = CNT_W'(IDX + 1) == count;
    assign is_free   = CNT_W'(IDX) == count;
    assign hit       = valid && (key_reg == ctl.key);
    assign shift_out = shift_in | hit;
    // unvisited entry behind the head that will expire in this sweep
    assign stale     = (IDX != 0) && (CNT_W'(IDX) < rem) && !seen_reg;

    assign entry.key  = key_reg;
    assign entry.seen = seen_reg;

    always_comb
    begin
        key_next  = key_reg;
        seen_next = seen_reg;
        case (ctl.mode)
            pat_pkg::MODE_APPEND:
            begin
                if (is_free)
                begin
                    key_next  = ctl.key;
                    seen_next = 1'b0;
                end
            end
            pat_pkg::MODE_MARK:
            begin
                if (hit)
                    seen_next = 1'b1;
            end
            pat_pkg::MODE_REMOVE:
            begin
                if (shift_out)
                begin
                    key_next  = nbr.key;
                    seen_next = nbr.seen;
                end
            end
            pat_pkg::MODE_KEEP:
            begin
                // head survives and goes to the tail with seen cleared
                if (is_tail)
                begin
                    key_next  = ctl.head_key;
                    seen_next = 1'b0;
                end
                else
                begin
                    key_next  = nbr.key;
                    seen_next = nbr.seen;
                end
            end
            pat_pkg::MODE_DROP:
            begin
                key_next  = nbr.key;
                seen_next = nbr.seen;
            end
            default:
            begin
                key_next  = key_reg;
                seen_next = seen_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 1'b0;
        else
            seen_reg <= seen_next;
    end

endmodule

`default_nettype wire
